@@ rtl/arpc_pkg.sv @@
// Shared constants and types of the ARP cache.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package arpc_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF = 8;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned AGE_W  = 8;

  // input operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_MSG    = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // ARP message kinds
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd1;

  localparam logic [IP_W-1:0]  IP_ALL_ONES   = '1;
  localparam logic [MAC_W-1:0] MAC_ALL_ONES  = '1;
  localparam logic [AGE_W-1:0] AGE_START_MAX = 8'hff;
  localparam logic [AGE_W-1:0] LIFETIME_RST  = 8'd120;

  // configuration register indexes (byte address bit 2)
  localparam logic REG_LOCAL_IP = 1'b0;
  localparam logic REG_LIFETIME = 1'b1;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef struct packed {
    logic   we;
    logic   valid;
    entry_t data;
  } store_wr_t;

endpackage

`default_nettype wire

@@ rtl/arpc_ifs.sv @@
// Valid/ready channel interfaces for the ARP cache requests and results.
// Depends on arpc_pkg for field widths.
`default_nettype none

interface arpc_req_if import arpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [KIND_W-1:0] arp_kind;
  logic [IP_W-1:0]   query_ip;
  logic [IP_W-1:0]   sender_ip;
  logic [MAC_W-1:0]  sender_mac;

  modport source (output valid, op, arp_kind, query_ip, sender_ip, sender_mac,
                  input ready);
  modport sink   (input valid, op, arp_kind, query_ip, sender_ip, sender_mac,
                  output ready);
endinterface

interface arpc_rsp_if import arpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [MAC_W-1:0] found_mac;
  logic             send_reply;
  logic             reply_seen;

  modport source (output valid, hit, found_mac, send_reply, reply_seen,
                  input ready);
  modport sink   (input valid, hit, found_mac, send_reply, reply_seen,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/arp_cache_with_aging.sv @@
// ARP cache with aging, top level; uses arpc_pkg, arpc_ifs, arpc_store, arpc_ctrl.
// A request is scanned one entry per cycle, then a message that learns writes its
// entry, then the result is registered. A new request is accepted only in idle,
// after the last result is registered; a result still held in the output register
// delays the next.
// Sync active-low reset: entries invalid (all ones, age 0), local_ip 0, lifetime 120.
`default_nettype none

module arp_cache_with_aging
  import arpc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  arpc_req_if.sink         in_if,
  arpc_rsp_if.source       out_if,
  // configuration: local_ip at 0x0, entry_lifetime at 0x4
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  logic [IP_W-1:0]  local_ip_r;
  logic [AGE_W-1:0] lifetime_r;
  logic             cfg_wr;

  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_data;
  logic [IDX_W-1:0] wr_idx;
  store_wr_t        wr;

  // --- configuration registers -------------------------------------------
  // Zero-wait APB: writes land on the access phase. Only address bit 2
  // selects the register; low bits are don't-care.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
      lifetime_r <= LIFETIME_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LOCAL_IP) begin
        local_ip_r <= pwdata;
      end else begin
        lifetime_r <= pwdata[AGE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_LIFETIME) begin
      prdata = {{(32-AGE_W){1'b0}}, lifetime_r};
    end else begin
      prdata = local_ip_r;
    end
  end

  // --- sequencer: one entry compared per cycle ----------------------------
  // Lookups pick the first IP match; learning overwrites a match or the
  // replacement victim; ticks decrement ages in place and drop expired
  // entries by clearing their valid bit.
  arpc_ctrl #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .local_ip (local_ip_r),
    .lifetime (lifetime_r),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_data  (rd_data),
    .wr_idx   (wr_idx),
    .wr       (wr)
  );

  // --- entry memory ---------------------------------------------------------
  arpc_store #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr_idx  (wr_idx),
    .wr      (wr)
  );

endmodule

`default_nettype wire

@@ rtl/arpc_store.sv @@
// Entry memory of the ARP cache: one read port (registered), one write port,
// plus a valid bit per entry so reset needs no clearing pass. Uses arpc_pkg.
`default_nettype none

module arpc_store
  import arpc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_idx,
  output entry_t                rd_data,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire store_wr_t        wr
);

  logic [IP_W-1:0]  ip_mem  [CACHE_ENTRIES];
  logic [MAC_W-1:0] mac_mem [CACHE_ENTRIES];
  logic [AGE_W-1:0] age_mem [CACHE_ENTRIES];

  logic [CACHE_ENTRIES-1:0] vld_r;
  entry_t                   rd_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      ip_mem[wr_idx]  <= wr.data.ip;
      mac_mem[wr_idx] <= wr.data.mac;
      age_mem[wr_idx] <= wr.data.age;
    end
    if (rd_en) begin
      rd_r.ip  <= ip_mem[rd_idx];
      rd_r.mac <= mac_mem[rd_idx];
      rd_r.age <= age_mem[rd_idx];
      rd_vld_r <= vld_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.we) begin
      vld_r[wr_idx] <= wr.valid;
    end
  end

  // an invalid entry reads as the reset contents
  always_comb begin
    if (rd_vld_r) begin
      rd_data = rd_r;
    end else begin
      rd_data.ip  = IP_ALL_ONES;
      rd_data.mac = MAC_ALL_ONES;
      rd_data.age = '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/arpc_ctrl.sv @@
// Sequencer and shared compare/select unit of the ARP cache: scans the entry
// memory one entry per cycle, then learns or answers. Uses arpc_pkg, arpc_ifs.
`default_nettype none

module arpc_ctrl
  import arpc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  arpc_req_if.sink              in_if,
  arpc_rsp_if.source            out_if,
  input  wire logic [IP_W-1:0]  local_ip,
  input  wire logic [AGE_W-1:0] lifetime,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_idx,
  input  wire entry_t           rd_data,
  output logic [IDX_W-1:0]      wr_idx,
  output store_wr_t             wr
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_LEARN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_LOOKUP = 3'd1;
  localparam logic [2:0] ACT_REQ    = 3'd2;
  localparam logic [2:0] ACT_RPL    = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  logic [1:0]       st_r, st_nxt;
  logic [2:0]       act_r, act_nxt;
  logic [IP_W-1:0]  key_r, key_nxt;
  logic [MAC_W-1:0] smac_r, smac_nxt;
  logic             bcast_r, bcast_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             issue_r, issue_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic             match_r, match_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic [MAC_W-1:0] match_mac_r, match_mac_nxt;
  logic [AGE_W-1:0] best_age_r, best_age_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             zero_r, zero_nxt;
  logic             ovld_r, ovld_nxt;
  logic             hit_r, hit_nxt;
  logic [MAC_W-1:0] fmac_r, fmac_nxt;
  logic             reply_r, reply_nxt;
  logic             seen_r, seen_nxt;

  logic [AGE_W-1:0] age_dec;
  logic             is_learn;

  assign age_dec  = rd_data.age - AGE_W'(1);
  assign is_learn = (act_r == ACT_REQ) || (act_r == ACT_RPL);

  assign in_if.ready       = (st_r == ST_IDLE);
  assign out_if.valid      = ovld_r;
  assign out_if.hit        = hit_r;
  assign out_if.found_mac  = fmac_r;
  assign out_if.send_reply = reply_r;
  assign out_if.reply_seen = seen_r;

  always_comb begin
    st_nxt        = st_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    smac_nxt      = smac_r;
    bcast_nxt     = bcast_r;
    rd_idx_nxt    = rd_idx_r;
    issue_nxt     = issue_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    match_mac_nxt = match_mac_r;
    best_age_nxt  = best_age_r;
    best_idx_nxt  = best_idx_r;
    zero_nxt      = zero_r;
    hit_nxt       = hit_r;
    fmac_nxt      = fmac_r;
    reply_nxt     = reply_r;
    seen_nxt      = seen_r;
    ovld_nxt      = ovld_r && !out_if.ready;

    rd_en    = (st_r == ST_SCAN) && issue_r;
    rd_idx   = rd_idx_r;
    pend_nxt = rd_en;
    pidx_nxt = rd_idx_r;
    wr_idx   = pidx_r;
    wr       = '0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          if (in_if.op == OP_LOOKUP) begin
            act_nxt = ACT_LOOKUP;
          end else if (in_if.op == OP_MSG) begin
            if (in_if.arp_kind == KIND_REQUEST) begin
              act_nxt = (in_if.query_ip == local_ip) ? ACT_REQ : ACT_NONE;
            end else if (in_if.arp_kind == KIND_REPLY) begin
              act_nxt = ACT_RPL;
            end else begin
              act_nxt = ACT_NONE;
            end
          end else if (in_if.op == OP_TICK) begin
            act_nxt = ACT_TICK;
          end else begin
            act_nxt = ACT_NONE;
          end
          key_nxt      = (in_if.op == OP_LOOKUP) ? in_if.query_ip : in_if.sender_ip;
          bcast_nxt    = (in_if.query_ip == IP_ALL_ONES);
          smac_nxt     = in_if.sender_mac;
          rd_idx_nxt   = '0;
          issue_nxt    = 1'b1;
          match_nxt    = 1'b0;
          best_age_nxt = AGE_START_MAX;
          best_idx_nxt = '0;
          zero_nxt     = 1'b0;
          st_nxt       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_r) begin
          if (rd_idx_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + IDX_W'(1);
          end
        end
        if (pend_r) begin
          // first matching IP
          if (!match_r && (rd_data.ip == key_r)) begin
            match_nxt     = 1'b1;
            match_idx_nxt = pidx_r;
            match_mac_nxt = rd_data.mac;
          end
          // replacement victim: first zero age, else last least age
          if (!zero_r && (rd_data.age <= best_age_r)) begin
            best_age_nxt = rd_data.age;
            best_idx_nxt = pidx_r;
          end
          if (rd_data.age == '0) begin
            zero_nxt = 1'b1;
          end
          if ((act_r == ACT_TICK) && (rd_data.age != '0)) begin
            wr.we       = 1'b1;
            wr.valid    = (age_dec != '0);
            wr.data.ip  = rd_data.ip;
            wr.data.mac = rd_data.mac;
            wr.data.age = age_dec;
          end
          if (pidx_r == LAST_IDX) begin
            st_nxt = is_learn ? ST_LEARN : ST_DONE;
          end
        end
      end
      ST_LEARN: begin
        wr_idx      = match_r ? match_idx_r : best_idx_r;
        wr.we       = 1'b1;
        wr.valid    = 1'b1;
        wr.data.ip  = key_r;
        wr.data.mac = smac_r;
        wr.data.age = lifetime;
        st_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!ovld_r || out_if.ready) begin
          ovld_nxt  = 1'b1;
          hit_nxt   = (act_r == ACT_LOOKUP) && (bcast_r || match_r);
          if (act_r != ACT_LOOKUP) begin
            fmac_nxt = '0;
          end else if (bcast_r) begin
            fmac_nxt = MAC_ALL_ONES;
          end else if (match_r) begin
            fmac_nxt = match_mac_r;
          end else begin
            fmac_nxt = '0;
          end
          reply_nxt = (act_r == ACT_REQ);
          seen_nxt  = (act_r == ACT_RPL);
          st_nxt    = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      issue_r <= issue_nxt;
      pend_r  <= pend_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    key_r       <= key_nxt;
    smac_r      <= smac_nxt;
    bcast_r     <= bcast_nxt;
    rd_idx_r    <= rd_idx_nxt;
    pidx_r      <= pidx_nxt;
    match_r     <= match_nxt;
    match_idx_r <= match_idx_nxt;
    match_mac_r <= match_mac_nxt;
    best_age_r  <= best_age_nxt;
    best_idx_r  <= best_idx_nxt;
    zero_r      <= zero_nxt;
    hit_r       <= hit_nxt;
    fmac_r      <= fmac_nxt;
    reply_r     <= reply_nxt;
    seen_r      <= seen_nxt;
  end

endmodule

`default_nettype wire
